// ===== src/pci_pkg.sv =====
package pci_pkg;

   localparam int INDEX_W = 8;
   localparam int COLOR_W = 24;
   localparam logic [INDEX_W-1:0] RESERVED_INDEX = 8'd255;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture pixel, clear scan state
      logic scan;    // step the palette read pointer
      logic commit;  // resolve index, append on a miss
      logic emit;    // move result into the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_key;
      logic hit;
      logic scan_done;
   } status_type;

endpackage

// ===== src/palette_color_indexer.sv =====
// Palette color indexer: maps RGB pixels to first-come palette indexes.
// req_ carries one pixel per transaction (red, green, blue, start_of_image);
// rsp_ returns color_index, new_color, palette_overflow and colors_used.
// Both channels: transaction when valid is high and stall is low.
// csr_ writes the transparent key color; csr_ready is always high, write
// only while no pixel is in flight.
// One pixel is in work at a time. The palette lives in a memory with one
// registered read port, scanned one entry per cycle in order of first
// appearance. The key color is resolved without a scan; a match ends the
// scan at the matching entry, and a miss scans every entry in use. The next
// pixel is accepted at the earliest in the cycle after the previous result
// is loaded.
// The result sits in an output register: while rsp_stall is high the next
// pixel is still accepted and scanned, and waits only to load its result.
// Reset (synchronous) empties the palette and sets the key color to black;
// palette memory contents are not cleared, the entry count hides them.
module palette_color_indexer #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_start_of_image,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_color_index,
   output logic        rsp_new_color,
   output logic        rsp_palette_overflow,
   output logic [7:0]  rsp_colors_used,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_transparent_color
);

   pci_pkg::cmd_type    cmd;
   pci_pkg::status_type status;

   assign csr_ready = 1'b1;

   pci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pci_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .req_start_of_image   (req_start_of_image),
      .key_write            (csr_valid && csr_ready),
      .key_data             (csr_transparent_color),
      .rsp_color_index      (rsp_color_index),
      .rsp_new_color        (rsp_new_color),
      .rsp_palette_overflow (rsp_palette_overflow),
      .rsp_colors_used      (rsp_colors_used)
   );

endmodule

// ===== src/pci_datapath.sv =====
module pci_datapath #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pci_pkg::cmd_type                   cmd,
   output pci_pkg::status_type                status,
   input  logic [7:0]                         req_red,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_blue,
   input  logic                               req_start_of_image,
   input  logic                               key_write,
   input  logic [pci_pkg::COLOR_W-1:0]        key_data,
   output logic [pci_pkg::INDEX_W-1:0]        rsp_color_index,
   output logic                               rsp_new_color,
   output logic                               rsp_palette_overflow,
   output logic [pci_pkg::INDEX_W-1:0]        rsp_colors_used
);

   // index 255 is reserved, so at most 255 entries
   localparam int CAP = (PALETTE_SIZE - 1 > 255) ? 255 : PALETTE_SIZE - 1;
   localparam int AW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);

   logic [pci_pkg::COLOR_W-1:0] mem [CAP];

   logic [pci_pkg::COLOR_W-1:0] key_ff,   key_in;
   logic [pci_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               ptr_ff,   ptr_in;
   logic                        pend_ff,  pend_in;
   logic [AW-1:0]               paddr_ff, paddr_in;
   logic [pci_pkg::COLOR_W-1:0] rdata_ff;
   logic [pci_pkg::INDEX_W-1:0] idx_ff,   idx_in;
   logic                        new_ff,   new_in;
   logic                        ovf_ff,   ovf_in;
   logic [pci_pkg::INDEX_W-1:0] out_idx_ff,  out_idx_in;
   logic                        out_new_ff,  out_new_in;
   logic                        out_ovf_ff,  out_ovf_in;
   logic [pci_pkg::INDEX_W-1:0] out_used_ff, out_used_in;

   logic rd_en;
   logic append;

   assign rd_en  = cmd.scan && (ptr_ff < count_ff);
   assign append = cmd.commit && !status.is_key && !status.hit
                   && (count_ff < CW'(CAP));

   assign status.is_key    = (color_ff == key_ff);
   assign status.hit       = pend_ff && (rdata_ff == color_ff);
   assign status.scan_done = (ptr_ff >= count_ff) && !pend_ff;

   always_comb begin
      key_in      = key_write ? key_data : key_ff;
      color_in    = color_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      paddr_in    = paddr_ff;
      idx_in      = idx_ff;
      new_in      = new_ff;
      ovf_in      = ovf_ff;
      out_idx_in  = out_idx_ff;
      out_new_in  = out_new_ff;
      out_ovf_in  = out_ovf_ff;
      out_used_in = out_used_ff;

      if (cmd.load) begin
         color_in = {req_red, req_green, req_blue};
         ptr_in   = '0;
         pend_in  = 1'b0;
         if (req_start_of_image) begin
            count_in = '0;
         end
      end else if (cmd.scan) begin
         pend_in  = rd_en;
         paddr_in = ptr_ff[AW-1:0];
         if (rd_en) begin
            ptr_in = ptr_ff + CW'(1);
         end
      end

      if (cmd.commit) begin
         idx_in = pci_pkg::RESERVED_INDEX;
         new_in = 1'b0;
         ovf_in = 1'b0;
         if (status.is_key) begin
            idx_in = pci_pkg::RESERVED_INDEX;
         end else if (status.hit) begin
            idx_in = pci_pkg::INDEX_W'(paddr_ff);
         end else if (append) begin
            idx_in   = pci_pkg::INDEX_W'(count_ff);
            new_in   = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         out_idx_in  = idx_ff;
         out_new_in  = new_ff;
         out_ovf_in  = ovf_ff;
         out_used_in = pci_pkg::INDEX_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         key_ff   <= key_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      paddr_ff    <= paddr_in;
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      ovf_ff      <= ovf_in;
      out_idx_ff  <= out_idx_in;
      out_new_ff  <= out_new_in;
      out_ovf_ff  <= out_ovf_in;
      out_used_ff <= out_used_in;
   end

   // palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (append) begin
         mem[count_ff[AW-1:0]] <= color_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[ptr_ff[AW-1:0]];
      end
   end

   assign rsp_color_index      = out_idx_ff;
   assign rsp_new_color        = out_new_ff;
   assign rsp_palette_overflow = out_ovf_ff;
   assign rsp_colors_used      = out_used_ff;

endmodule

// ===== src/pci_ctrl.sv =====
module pci_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pci_pkg::status_type status,
   output pci_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      decide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign decide    = status.is_key || status.hit || status.scan_done;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (decide) begin
               cmd.commit = 1'b1;
               state_in   = RESULT;
            end
         end
         RESULT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== tb/tb_palette_color_indexer.sv =====
module tb_palette_color_indexer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PALETTE_SIZE   = 256;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 300;  // longer than a full palette scan

   typedef struct packed {
      logic [pci_pkg::INDEX_W-1:0] color_index;
      logic                        new_color;
      logic                        palette_overflow;
      logic [pci_pkg::INDEX_W-1:0] colors_used;
   } index_result_type;

   // Keeps a shadow palette and the key color, and the index results still owed by the block.
   class palette_index_checker;
      logic [pci_pkg::COLOR_W-1:0] key_color;
      logic [pci_pkg::COLOR_W-1:0] shadow_palette [0:254];
      int unsigned                 shadow_count;
      int unsigned                 max_entries;
      index_result_type            owed_results [$];
      int                          errors;

      function new(int unsigned palette_size);
         key_color    = '0;
         shadow_count = 0;
         max_entries  = (palette_size > 1) ? palette_size - 1 : 0;
         if (max_entries > 255) max_entries = 255;
         errors = 0;
      endfunction

      function void set_key(logic [pci_pkg::COLOR_W-1:0] value);
         key_color = value;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void index_pixel(logic [pci_pkg::COLOR_W-1:0] rgb, logic sof);
         index_result_type res;
         int unsigned      j;
         bit               hit;
         res = '0;
         res.color_index = pci_pkg::RESERVED_INDEX;
         hit = 0;
         if (sof) shadow_count = 0;
         if (rgb != key_color) begin
            for (j = 0; j < shadow_count; j++) begin
               if (!hit && shadow_palette[j] == rgb) begin
                  res.color_index = 8'(j);
                  hit = 1;
               end
            end
            if (!hit) begin
               if (shadow_count < max_entries) begin
                  shadow_palette[shadow_count] = rgb;
                  res.color_index = 8'(shadow_count);
                  res.new_color = 1'b1;
                  shadow_count++;
               end else begin
                  res.palette_overflow = 1'b1;
               end
            end
         end
         res.colors_used = 8'(shadow_count);
         owed_results.push_back(res);
      endfunction

      function void check_index(index_result_type got);
         index_result_type want;
         if (owed_results.size() == 0) begin
            $error("unexpected result transaction: color_index %0d", got.color_index);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (got.color_index != want.color_index) begin
            $error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
            errors++;
         end
         if (got.new_color != want.new_color) begin
            $error("new_color: expected %0d, actual %0d", want.new_color, got.new_color);
            errors++;
         end
         if (got.palette_overflow != want.palette_overflow) begin
            $error("palette_overflow: expected %0d, actual %0d",
                   want.palette_overflow, got.palette_overflow);
            errors++;
         end
         if (got.colors_used != want.colors_used) begin
            $error("colors_used: expected %0d, actual %0d", want.colors_used, got.colors_used);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        req_start_of_image = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_color_index;
   logic        rsp_new_color;
   logic        rsp_palette_overflow;
   logic [7:0]  rsp_colors_used;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_transparent_color = '0;

   palette_index_checker checker_h;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int mode_left = 50;

   palette_color_indexer #(
      .PALETTE_SIZE(PALETTE_SIZE)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .req_start_of_image   (req_start_of_image),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_color_index      (rsp_color_index),
      .rsp_new_color        (rsp_new_color),
      .rsp_palette_overflow (rsp_palette_overflow),
      .rsp_colors_used      (rsp_colors_used),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_transparent_color(csr_transparent_color)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver: stall behavior switches between modes every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left = mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            checker_h.check_index({rsp_color_index, rsp_new_color, rsp_palette_overflow,
                                   rsp_colors_used});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_palette_color_indexer: errors");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [23:0] rgb, input logic sof);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_red            <= rgb[23:16];
      req_green          <= rgb[15:8];
      req_blue           <= rgb[7:0];
      req_start_of_image <= sof;
      do @(posedge clock); while (!(req_valid && !req_stall));
      checker_h.index_pixel(rgb, sof);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (checker_h.pending() != 0) @(posedge clock);
   endtask

   task automatic write_key(input logic [23:0] value);
      csr_valid             <= 1'b1;
      csr_transparent_color <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      checker_h.set_key(value);
      csr_valid <= 1'b0;
   endtask

   // images: sof then pixels drawn mostly from a small pool of colors
   task automatic run_images(input int n_items);
      logic [23:0] pool [0:23];
      int          pool_size;
      int          img_len;
      int          left;
      int          k;
      int          pick;
      logic [23:0] rgb;
      logic        sof;
      left = n_items;
      while (left > 0) begin
         pool_size = $urandom_range(1, 24);
         for (k = 0; k < pool_size; k++) pool[k] = 24'($urandom);
         img_len = $urandom_range(4, 40);
         for (k = 0; k < img_len && left > 0; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) rgb = checker_h.key_color;
            else if (pick == 1) rgb = 24'($urandom);
            else rgb = pool[$urandom_range(0, pool_size - 1)];
            // broken image starts and stray start flags now and then
            if (k == 0) sof = ($urandom_range(0, 7) != 0);
            else sof = ($urandom_range(0, 49) == 0);
            send_pixel(rgb, sof);
            left--;
         end
      end
   endtask

   initial begin
      int i;
      checker_h = new(PALETTE_SIZE);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_key(24'h000000);
      send_pixel(24'h000000, 1'b1);  // key pixel at start of image
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'h010000, 1'b0);
      send_pixel(24'h808080, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'hAA55AA, 1'b0);
      send_pixel(24'h55AA55, 1'b0);
      send_pixel(24'h000000, 1'b1);  // palette emptied even for a key pixel
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h000000, 1'b0);
      wait_drained();

      // key moved onto a color already in the palette: that entry goes unmatched
      write_key(24'hFF0000);
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h123456, 1'b0);
      wait_drained();

      // fill the palette to capacity and beyond
      write_key(24'hFFFFFF);
      send_pixel(24'hFFFFFF, 1'b0);
      for (i = 0; i < 260; i++) send_pixel({8'h10, 8'(i >> 8), 8'(i)}, (i == 0));
      send_pixel({8'h10, 8'h00, 8'h00}, 1'b0);
      send_pixel({8'h10, 8'h00, 8'd254}, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h200000, 1'b0);
      send_pixel(24'h200000, 1'b1);
      wait_drained();

      for (i = 0; i < 8; i++) begin
         case (i)
            0: write_key(24'h000000);
            1: write_key(24'hFFFFFF);
            default: write_key(24'($urandom));
         endcase
         run_images(30);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (checker_h.errors == 0 && checker_h.pending() == 0)
         $display("tb_palette_color_indexer: clean");
      else
         $display("tb_palette_color_indexer: errors");
      $finish;
   end

endmodule
